/* sv/assert_macros.svh */
// Assertion macros shared by the RTL of the ring buffer deque.
// Needs no other file; assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: always");
// Antecedent implies consequent on the following edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* sv/rbd_pkg.sv */
// Types and codes of the ring buffer deque.
// Used by rbd_cell, ring_buffer_deque_top and the testbench; depends on nothing.
package rbd_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned OCC_W   = 4;

    typedef enum logic [1:0] {
        CMD_PUSH_BACK  = 2'd0,
        CMD_PUSH_FRONT = 2'd1,
        CMD_POP_BACK   = 2'd2,
        CMD_POP_FRONT  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    // Operation broadcast to every cell of the row alike.
    typedef struct packed {
        logic               add_front;
        logic               take_front;
        logic               add_back;
        logic               take_back;
        logic [VALUE_W-1:0] value;
    } cell_op_t;

endpackage

/* sv/rbd_cell.sv */
// One slot of the deque row: a data word and an occupied flag.
// Depends on rbd_pkg; neighbors feed it on shifts toward either end.
module rbd_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rbd_pkg::cell_op_t              op,
    input  logic [rbd_pkg::VALUE_W-1:0]    left_data,
    input  logic                           left_valid,
    input  logic [rbd_pkg::VALUE_W-1:0]    right_data,
    input  logic                           right_valid,
    output logic [rbd_pkg::VALUE_W-1:0]    data,
    output logic                           valid,
    output logic [rbd_pkg::VALUE_W-1:0]    tail_data
);
    import rbd_pkg::*;

    logic [VALUE_W-1:0] data_reg;
    logic [VALUE_W-1:0] data_next;
    logic               valid_reg;
    logic               valid_next;

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (op.add_front)
        begin
            data_next  = left_data;
            valid_next = left_valid;
        end
        else if (op.take_front)
        begin
            data_next  = right_data;
            valid_next = right_valid;
        end
        else if (op.add_back)
        begin
            // first free slot: left neighbor occupied, this one not
            if (!valid_reg && left_valid)
            begin
                data_next  = op.value;
                valid_next = 1'b1;
            end
        end
        else if (op.take_back)
        begin
            if (valid_reg && !right_valid)
                valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data      = data_reg;
    assign valid     = valid_reg;
    // only the last occupied cell drives its word onto the back read
    assign tail_data = (valid_reg && !right_valid) ? data_reg : '0;

endmodule

/* sv/ring_buffer_deque_top.sv */
// Ring buffer deque: top level, a row of DEPTH rbd_cell slots plus count and result register.
// Depends on rbd_pkg, rbd_cell and assert_macros.svh.
//
// Usage:
//   Input channel in_valid/in_ready carries cmd and push_value; each beat is
//   one command (push back, push front, pop back, pop front).
//   Output channel out_valid/out_ready carries one result beat per command:
//   status, popped_value, occupancy, is_full, is_empty.
//   Front entry always sits in cell 0; push/pop at the front shift the whole
//   row by one cell, push/pop at the back touch only the boundary cell.
//   Result: registered when the command beat is taken, offered in the next cycle.
//   Throughput: one command per cycle; the result register is refilled in
//   the same cycle it is taken, so in_ready stays high while out_ready does.
//   Receiver stall: with a result waiting and out_ready low, in_ready drops
//   and the row holds its contents.
//   Reset: all slots empty, count zero, no result pending; the block takes
//   commands as soon as reset is released.
`include "assert_macros.svh"
module ring_buffer_deque_top #(
    parameter int unsigned DEPTH = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    cmd,
    input  logic [rbd_pkg::VALUE_W-1:0]   push_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic [rbd_pkg::VALUE_W-1:0]   popped_value,
    output logic [rbd_pkg::OCC_W-1:0]     occupancy,
    output logic                          is_full,
    output logic                          is_empty
);
    import rbd_pkg::*;

    localparam int unsigned CW    = $clog2(DEPTH + 1);
    localparam int unsigned EXT_W = (CW > OCC_W) ? CW : OCC_W;

    cmd_t               cmd_in;
    logic               accept;
    logic               full_now;
    logic               empty_now;
    logic               do_push;
    logic               do_pop;
    cell_op_t           op;

    logic [VALUE_W-1:0] cell_data  [DEPTH];
    logic               cell_valid [DEPTH];
    logic [VALUE_W-1:0] cell_tail  [DEPTH];
    logic [VALUE_W-1:0] back_word;
    logic [DEPTH-1:0]   valid_vec;

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [EXT_W-1:0]   count_ext;

    logic               out_valid_reg;
    logic               out_valid_next;
    status_t            status_reg;
    status_t            status_next;
    logic [VALUE_W-1:0] popped_reg;
    logic [VALUE_W-1:0] popped_next;
    logic [OCC_W-1:0]   occ_reg;
    logic               full_reg;
    logic               empty_reg;

    assign cmd_in    = cmd_t'(cmd);
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign full_now  = (count_reg == CW'(DEPTH));
    assign empty_now = (count_reg == '0);

    assign do_push = accept && !full_now
                     && ((cmd_in == CMD_PUSH_BACK) || (cmd_in == CMD_PUSH_FRONT));
    assign do_pop  = accept && !empty_now
                     && ((cmd_in == CMD_POP_BACK) || (cmd_in == CMD_POP_FRONT));

    always_comb
    begin
        op.add_front  = do_push && (cmd_in == CMD_PUSH_FRONT);
        op.add_back   = do_push && (cmd_in == CMD_PUSH_BACK);
        op.take_front = do_pop && (cmd_in == CMD_POP_FRONT);
        op.take_back  = do_pop && (cmd_in == CMD_POP_BACK);
        op.value      = push_value;
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [VALUE_W-1:0] l_data;
            logic               l_valid;
            logic [VALUE_W-1:0] r_data;
            logic               r_valid;

            if (gi == 0)
            begin : g_head
                assign l_data  = push_value;
                assign l_valid = 1'b1;
            end
            else
            begin : g_mid_l
                assign l_data  = cell_data[gi-1];
                assign l_valid = cell_valid[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_tail
                assign r_data  = '0;
                assign r_valid = 1'b0;
            end
            else
            begin : g_mid_r
                assign r_data  = cell_data[gi+1];
                assign r_valid = cell_valid[gi+1];
            end

            rbd_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .op          (op),
                .left_data   (l_data),
                .left_valid  (l_valid),
                .right_data  (r_data),
                .right_valid (r_valid),
                .data        (cell_data[gi]),
                .valid       (cell_valid[gi]),
                .tail_data   (cell_tail[gi])
            );

            assign valid_vec[gi] = cell_valid[gi];
        end
    endgenerate

    // at most one cell drives a nonzero tail word
    always_comb
    begin
        back_word = '0;
        for (int i = 0; i < DEPTH; i++)
            back_word = back_word | cell_tail[i];
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_push)
            count_next = count_reg + CW'(1);
        else if (do_pop)
            count_next = count_reg - CW'(1);
        count_ext = EXT_W'(count_next);
    end

    always_comb
    begin
        status_next = ST_DONE;
        popped_next = '0;
        if ((cmd_in == CMD_PUSH_BACK) || (cmd_in == CMD_PUSH_FRONT))
        begin
            if (full_now)
                status_next = ST_OVERFLOW;
        end
        else if (empty_now)
            status_next = ST_UNDERFLOW;
        else if (cmd_in == CMD_POP_FRONT)
            popped_next = cell_data[0];
        else
            popped_next = back_word;

        out_valid_next = out_valid_reg;
        if (accept)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            popped_reg <= popped_next;
            occ_reg    <= count_ext[OCC_W-1:0];
            full_reg   <= (count_next == CW'(DEPTH));
            empty_reg  <= (count_next == '0);
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign popped_value = popped_reg;
    assign occupancy    = occ_reg;
    assign is_full      = full_reg;
    assign is_empty     = empty_reg;

    // occupied cells form a run starting at cell 0
    `ASSERT_ALWAYS(a_valid_packed, clk, rst_n, $onehot({1'b0, valid_vec} + (DEPTH + 1)'(1)))
    // count tracks the occupied cells
    `ASSERT_ALWAYS(a_count_match, clk, rst_n, $countones(valid_vec) == int'(count_reg))
    // never above capacity
    `ASSERT_ALWAYS(a_count_range, clk, rst_n, count_reg <= CW'(DEPTH))
    // a refused push leaves the row untouched and yields an overflow result with is_full set
    `ASSERT_NEXT(a_overflow_hold, clk, rst_n, accept && full_now && !cmd[1], $stable(valid_vec) && out_valid && (status == ST_OVERFLOW) && is_full)

endmodule

/* tb/sv/rbd_deque_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for ring_buffer_deque_top: mirrors the deque contents, predicts one
// result per command beat and compares every result beat. Depends on rbd_pkg.
module rbd_deque_checker #(
    parameter int unsigned DEPTH = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [1:0]                  cmd,
    input  logic [rbd_pkg::VALUE_W-1:0] push_value,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [1:0]                  status,
    input  logic [rbd_pkg::VALUE_W-1:0] popped_value,
    input  logic [rbd_pkg::OCC_W-1:0]   occupancy,
    input  logic                        is_full,
    input  logic                        is_empty,
    output int                          error_count,
    output int                          results_pending
);
    import rbd_pkg::*;

    typedef struct packed {
        status_t            status;
        logic [VALUE_W-1:0] popped_value;
        logic [OCC_W-1:0]   occupancy;
        logic               is_full;
        logic               is_empty;
    } deque_result_t;

    // front of the deque is element 0
    logic [VALUE_W-1:0] deque_words[$];
    deque_result_t      expected_results[$];
    int                 errors = 0;

    function automatic deque_result_t apply_deque_cmd(cmd_t op, logic [VALUE_W-1:0] value);
        deque_result_t r;
        r.status       = ST_DONE;
        r.popped_value = '0;
        if (op == CMD_PUSH_BACK || op == CMD_PUSH_FRONT)
        begin
            if (deque_words.size() >= DEPTH)
                r.status = ST_OVERFLOW;
            else if (op == CMD_PUSH_BACK)
                deque_words.insert(deque_words.size(), value);
            else
                deque_words.insert(0, value);
        end
        else
        begin
            if (deque_words.size() == 0)
                r.status = ST_UNDERFLOW;
            else if (op == CMD_POP_BACK)
            begin
                r.popped_value = deque_words[deque_words.size() - 1];
                deque_words.delete(deque_words.size() - 1);
            end
            else
            begin
                r.popped_value = deque_words[0];
                deque_words.delete(0);
            end
        end
        r.occupancy = OCC_W'(deque_words.size());
        r.is_full   = (deque_words.size() >= DEPTH);
        r.is_empty  = (deque_words.size() == 0);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
                               input logic [VALUE_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        deque_result_t want;
        if (rst_n)
        begin
            // a result always trails its command, never in the same cycle
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result beat with no command outstanding");
                    errors++;
                end
                else
                begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    check_field("status", VALUE_W'(want.status), VALUE_W'(status));
                    check_field("popped_value", want.popped_value, popped_value);
                    check_field("occupancy", VALUE_W'(want.occupancy), VALUE_W'(occupancy));
                    check_field("is_full", VALUE_W'(want.is_full), VALUE_W'(is_full));
                    check_field("is_empty", VALUE_W'(want.is_empty), VALUE_W'(is_empty));
                end
            end
            if (in_valid && in_ready)
                expected_results.insert(expected_results.size(),
                                        apply_deque_cmd(cmd_t'(cmd), push_value));
        end
        error_count     <= errors;
        results_pending <= expected_results.size();
    end

endmodule

/* tb/sv/ring_buffer_deque_top_tb.sv */
`timescale 1ns / 100ps
// Testbench top for ring_buffer_deque_top: clock, reset, command and result traffic
// with random idling, and the verdict; needs rbd_pkg, rbd_deque_checker and the DUT.
module ring_buffer_deque_top_tb;
    import rbd_pkg::*;

    localparam int unsigned DEPTH     = 8;
    localparam int          NUM_RAND  = 1800;
    localparam int          LONG_HOLD = 150;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         cmd;
    logic [VALUE_W-1:0] push_value;
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         status;
    logic [VALUE_W-1:0] popped_value;
    logic [OCC_W-1:0]   occupancy;
    logic               is_full;
    logic               is_empty;
    int                 error_count;
    int                 results_pending;
    logic               no_idle = 1'b0;

    always #1 clk = ~clk;

    ring_buffer_deque_top #(.DEPTH(DEPTH)) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .push_value   (push_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .popped_value (popped_value),
        .occupancy    (occupancy),
        .is_full      (is_full),
        .is_empty     (is_empty)
    );

    rbd_deque_checker #(.DEPTH(DEPTH)) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .cmd             (cmd),
        .push_value      (push_value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .popped_value    (popped_value),
        .occupancy       (occupancy),
        .is_full         (is_full),
        .is_empty        (is_empty),
        .error_count     (error_count),
        .results_pending (results_pending)
    );

    // mostly none or short, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [VALUE_W-1:0] random_word();
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_beat(input cmd_t op, input logic [VALUE_W-1:0] value);
        int gap;
        in_valid   <= 1'b1;
        cmd        <= op;
        push_value <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // sender stays quiet until every outstanding result has been taken
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (results_pending == 0);
        @(posedge clk);
    endtask

    initial
    begin : receiver
        int run;
        int hold;
        int round;
        round = 0;
        out_ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            run = $urandom_range(1, 30);
            out_ready <= 1'b1;
            repeat (run) @(posedge clk);
            round++;
            // long hold-off backs the sender up against a stalled input
            if (round == 25 || round == 90)
                hold = LONG_HOLD;
            else
                hold = pick_gap();
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        int   n;
        int   seg_left;
        int   push_pct;
        cmd_t op;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        cmd        <= CMD_PUSH_BACK;
        push_value <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // underflow on both ends of an empty deque
        send_beat(CMD_POP_BACK, 32'h1234_5678);
        send_beat(CMD_POP_FRONT, 32'hffff_ffff);
        // push at both ends, then two pops from the back empty the deque again
        send_beat(CMD_PUSH_BACK, 32'h7fff_ffff);
        send_beat(CMD_PUSH_FRONT, 32'h8000_0000);
        send_beat(CMD_POP_BACK, 32'h0);
        send_beat(CMD_POP_BACK, 32'h0);
        // fill from both ends
        send_beat(CMD_PUSH_BACK, 32'h0000_0000);
        send_beat(CMD_PUSH_BACK, 32'hffff_ffff);
        send_beat(CMD_PUSH_BACK, 32'haaaa_aaaa);
        send_beat(CMD_PUSH_BACK, 32'h5555_5555);
        send_beat(CMD_PUSH_FRONT, 32'h0000_0001);
        send_beat(CMD_PUSH_FRONT, 32'h5555_5555);
        send_beat(CMD_PUSH_FRONT, 32'haaaa_aaaa);
        send_beat(CMD_PUSH_FRONT, 32'h8000_0000);
        // overflow at both ends of a full deque
        send_beat(CMD_PUSH_BACK, 32'hdead_beef);
        send_beat(CMD_PUSH_FRONT, 32'h7fff_ffff);
        for (n = 0; n < 4; n++)
        begin
            send_beat(CMD_POP_FRONT, 32'haaaa_aaaa);
            send_beat(CMD_POP_BACK, 32'h5555_5555);
        end
        send_beat(CMD_POP_FRONT, 32'h0);
        wait_for_results();

        // random walk: push-heavy and pop-heavy stretches reach full and empty
        seg_left = 0;
        push_pct = 50;
        for (n = 0; n < NUM_RAND; n++)
        begin
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(8, 40);
                case ($urandom_range(0, 2))
                    0:       push_pct = 80;
                    1:       push_pct = 20;
                    default: push_pct = 50;
                endcase
                no_idle = ($urandom_range(0, 3) == 0);
            end
            seg_left--;
            if ($urandom_range(0, 99) < push_pct)
                op = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
            else
                op = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
            send_beat(op, random_word());
            if (n % 400 == 399)
                wait_for_results();
        end

        in_valid <= 1'b0;
        @(posedge clk);
        wait (results_pending == 0);
        repeat (10) @(posedge clk);
        if (error_count == 0 && results_pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+sv
sv/rbd_pkg.sv
sv/rbd_cell.sv
sv/ring_buffer_deque_top.sv
tb/sv/rbd_deque_checker.sv
tb/sv/ring_buffer_deque_top_tb.sv
